[design/assert_macros.svh]
// Assertion macros for the byte ring FIFO modules.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define DBRF_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define DBRF_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/dbrf_pkg.sv]
// Package for the delimited byte ring FIFO: field widths, command codes and
// the request and result record types. Depends on nothing.
`default_nettype none

package dbrf_pkg;

   localparam int DEFAULT_DEPTH = 1024;

   localparam int MODE_W     = 2;
   localparam int BYTE_W     = 8;
   localparam int LIMIT_W    = 7;
   localparam int OUT_CNT_W  = 11;
   localparam int MAX_RES    = 64;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 32;

   localparam logic [MODE_W-1:0] MODE_PUT  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_GET  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DROP = 2'd2;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [BYTE_W-1:0]  put_byte;
      logic [LIMIT_W-1:0] read_limit;
      logic [BYTE_W-1:0]  stop_byte;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0]    data_byte;
      logic                 byte_valid;
      logic                 last;
      logic                 accepted;
      logic [OUT_CNT_W-1:0] dropped_count;
      logic [OUT_CNT_W-1:0] occupancy;
   } rsp_type;

endpackage

`default_nettype wire

[design/dbrf_mem.sv]
// Byte store of the ring FIFO: one write port and one read port, registered
// read data that holds while no read is issued. Depends on nothing.
`default_nettype none

module dbrf_mem #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [7:0]        wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [7:0]        rd_data
);

   logic [7:0] store_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= store_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

[design/dbrf_ctrl.sv]
// Command sequencer of the ring FIFO: indices, fill count, get and drop walks
// and the result register. Depends on dbrf_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module dbrf_ctrl #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire dbrf_pkg::req_type req,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output dbrf_pkg::rsp_type      rsp,
   output logic                   mem_wr_en,
   output logic      [ADDR_W-1:0] mem_wr_addr,
   output logic      [7:0]        mem_wr_data,
   output logic                   mem_rd_en,
   output logic      [ADDR_W-1:0] mem_rd_addr,
   input  wire logic [7:0]        mem_rd_data
);
   import dbrf_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0]  FULL     = CNT_W'(DEPTH);
   localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(DEPTH - 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_GET  = 2'd1;
   localparam logic [1:0] ST_DROP = 2'd2;

   function automatic logic [ADDR_W-1:0] adv(input logic [ADDR_W-1:0] i);
      return (i == LAST_IDX) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [ADDR_W-1:0] back(input logic [ADDR_W-1:0] i);
      return (i == '0) ? LAST_IDX : i - 1'b1;
   endfunction

   function automatic logic [OUT_CNT_W-1:0] to_out(input logic [CNT_W-1:0] v);
      logic [CNT_W+OUT_CNT_W-1:0] ext;
      ext = {{OUT_CNT_W{1'b0}}, v};
      return ext[OUT_CNT_W-1:0];
   endfunction

   logic [1:0]         state_ff, state_in;
   logic [ADDR_W-1:0]  read_ff, read_in;
   logic [ADDR_W-1:0]  write_ff, write_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic [LIMIT_W-1:0] rem_ff, rem_in;
   logic [BYTE_W-1:0]  stop_ff, stop_in;
   logic [CNT_W-1:0]   removed_ff, removed_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic                       out_free;
   logic                       emit;
   rsp_type                    emit_rsp;
   logic [LIMIT_W-1:0]         lim_sat;
   logic [CNT_W+LIMIT_W-1:0]   fill_ext;
   logic [CNT_W+LIMIT_W-1:0]   lim_ext;
   logic [LIMIT_W-1:0]         get_n;
   logic                       fin;
   logic [CNT_W-1:0]           removed_inc;
   logic                       walking;
   logic                       refused_put;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      lim_sat  = (req.read_limit > LIMIT_W'(MAX_RES)) ? LIMIT_W'(MAX_RES) : req.read_limit;
      fill_ext = {{LIMIT_W{1'b0}}, fill_ff};
      lim_ext  = {{CNT_W{1'b0}}, lim_sat};
      get_n    = (fill_ext < lim_ext) ? fill_ext[LIMIT_W-1:0] : lim_sat;
   end

   assign fin         = (mem_rd_data == stop_ff) || (rem_ff == LIMIT_W'(1));
   assign removed_inc = removed_ff + 1'b1;

   always_comb begin
      state_in     = state_ff;
      read_in      = read_ff;
      write_in     = write_ff;
      fill_in      = fill_ff;
      rem_in       = rem_ff;
      stop_in      = stop_ff;
      removed_in   = removed_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = write_ff;
      mem_wr_data  = req.put_byte;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = read_ff;
      req_ready    = (state_ff == ST_IDLE) && out_free;
      emit         = 1'b0;
      emit_rsp     = '0;
      emit_rsp.last = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               unique case (req.mode)
                  MODE_PUT: begin
                     emit = 1'b1;
                     if (fill_ff != FULL) begin
                        mem_wr_en         = 1'b1;
                        write_in          = adv(write_ff);
                        fill_in           = fill_ff + 1'b1;
                        emit_rsp.accepted = 1'b1;
                     end
                  end
                  MODE_GET: begin
                     if (get_n == '0) begin
                        emit = 1'b1;
                     end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = read_ff;
                        rem_in      = get_n;
                        stop_in     = req.stop_byte;
                        state_in    = ST_GET;
                     end
                  end
                  MODE_DROP: begin
                     if (fill_ff == '0) begin
                        emit = 1'b1;
                     end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = back(write_ff);
                        stop_in     = req.stop_byte;
                        removed_in  = '0;
                        state_in    = ST_DROP;
                     end
                  end
                  default: begin
                     emit = 1'b1;
                  end
               endcase
            end
         end
         ST_GET: begin
            if (out_free) begin
               emit                = 1'b1;
               read_in             = adv(read_ff);
               fill_in             = fill_ff - 1'b1;
               rem_in              = rem_ff - 1'b1;
               emit_rsp.data_byte  = mem_rd_data;
               emit_rsp.byte_valid = 1'b1;
               emit_rsp.last       = fin;
               if (fin) begin
                  state_in = ST_IDLE;
               end else begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = adv(read_ff);
               end
            end
         end
         ST_DROP: begin
            if (mem_rd_data == stop_ff) begin
               if (out_free) begin
                  emit                   = 1'b1;
                  emit_rsp.dropped_count = to_out(removed_ff);
                  state_in               = ST_IDLE;
               end
            end else if (fill_ff == CNT_W'(1)) begin
               if (out_free) begin
                  emit                   = 1'b1;
                  write_in               = back(write_ff);
                  fill_in                = '0;
                  emit_rsp.dropped_count = to_out(removed_inc);
                  state_in               = ST_IDLE;
               end
            end else begin
               write_in    = back(write_ff);
               fill_in     = fill_ff - 1'b1;
               removed_in  = removed_inc;
               mem_rd_en   = 1'b1;
               mem_rd_addr = back(back(write_ff));
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (emit) begin
         emit_rsp.occupancy = to_out(fill_in);
         rsp_valid_in       = 1'b1;
         rsp_in             = emit_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         read_ff      <= '0;
         write_ff     <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         read_ff      <= read_in;
         write_ff     <= write_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      stop_ff    <= stop_in;
      removed_ff <= removed_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   assign walking     = (state_ff != ST_IDLE);
   assign refused_put = req_valid && req_ready && (req.mode == MODE_PUT) && (fill_ff == FULL);

   `DBRF_ASSERT_IMP(a_fill_bound, clock, reset, 1'b1, fill_ff <= FULL, "fill count above depth")
   `DBRF_ASSERT_IMP(a_walk_nonempty, clock, reset, walking, fill_ff != '0, "walk on empty FIFO")
   `DBRF_ASSERT_IMP(a_get_rem, clock, reset, state_ff == ST_GET, rem_ff != '0, "get count zero")
   `DBRF_ASSERT_NXT(a_full_put, clock, reset, refused_put, $stable(fill_ff), "refused put moved fill")

endmodule

`default_nettype wire

[design/delimited_byte_ring_fifo.sv]
// Top level of the delimited byte ring FIFO: stream ports, field packing,
// sequencer and byte store. Depends on dbrf_pkg, dbrf_ctrl and dbrf_mem.
//
//   Channel  Direction  Carries
//   req_     in         one command transaction: mode, put byte, read limit, stop byte
//   rsp_     out        result transactions: popped byte, flags, drop count, occupancy
//
// A put writes its byte in the idle state unless the FIFO is full. A get reads the oldest
// byte first and pops up to its limit or stop byte; a drop reads back from the newest byte
// until its stop byte or an empty FIFO. Both walk the single read port, one entry a cycle.
// Reset is synchronous; the byte store is not cleared.
// A held result stalls the walk only where a result is due; a command is taken once the
// previous one has finished and the result register is free or draining.
`default_nettype none

module delimited_byte_ring_fifo #(
   parameter int DEPTH = dbrf_pkg::DEFAULT_DEPTH
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // put_byte [7:0], read_limit [14:8], stop_byte [22:15], zero [23]
   input  wire logic [dbrf_pkg::REQ_DATA_W-1:0] req_tdata,
   // mode [1:0]
   input  wire logic [dbrf_pkg::MODE_W-1:0]     req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // data_byte [7:0], accepted [8], dropped_count [19:9], occupancy [30:20], zero [31]
   output logic      [dbrf_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // byte_valid [0]
   output logic                                 rsp_tuser,
   output logic                                 rsp_tlast
);
   import dbrf_pkg::*;

   localparam int ADDR_W = $clog2(DEPTH);

   req_type           req;
   rsp_type           rsp;
   logic              mem_wr_en;
   logic [ADDR_W-1:0] mem_wr_addr;
   logic [7:0]        mem_wr_data;
   logic              mem_rd_en;
   logic [ADDR_W-1:0] mem_rd_addr;
   logic [7:0]        mem_rd_data;

   always_comb begin
      req.mode       = req_tuser;
      req.put_byte   = req_tdata[7:0];
      req.read_limit = req_tdata[14:8];
      req.stop_byte  = req_tdata[22:15];
   end

   assign rsp_tdata = {1'b0, rsp.occupancy, rsp.dropped_count, rsp.accepted, rsp.data_byte};
   assign rsp_tuser = rsp.byte_valid;
   assign rsp_tlast = rsp.last;

   dbrf_ctrl #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req         (req),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp         (rsp),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   dbrf_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

`default_nettype wire

[tb/delimited_byte_ring_fifo_tb.sv]
// Self-checking testbench for delimited_byte_ring_fifo: a queue-fed stream driver, a result
// monitor that checks against a cycle-free model of the byte ring, and a no-progress watchdog.
// Depends on dbrf_pkg and the delimited_byte_ring_fifo RTL.
`timescale 1ns / 1ps

module delimited_byte_ring_fifo_tb;
   import dbrf_pkg::*;

   localparam int PERIOD      = 8;
   localparam int DEPTH       = DEFAULT_DEPTH;
   localparam int STALL_LIMIT = 8000;
   localparam int ITEMS_PER_PHASE = 160;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [MODE_W-1:0]     req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;

   req_type pending_cmds[$];
   rsp_type expected_rsps[$];
   req_type cmd_on_bus;

   logic [7:0] ring_bytes [DEPTH];
   int ring_rd;
   int ring_wr;
   int ring_fill;

   int send_idle_pct;
   int recv_idle_pct;
   int error_count;
   int cmds_queued;
   int cmds_taken;
   int rsps_seen;
   int idle_cycles;

   delimited_byte_ring_fifo #(.DEPTH(DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #(PERIOD / 2) clock = ~clock;

   function automatic void push_result(input logic [7:0] data, input logic valid,
                                       input logic fin, input logic acc, input int dropped);
      rsp_type r;
      r.data_byte     = data;
      r.byte_valid    = valid;
      r.last          = fin;
      r.accepted      = acc;
      r.dropped_count = dropped[OUT_CNT_W-1:0];
      r.occupancy     = ring_fill[OUT_CNT_W-1:0];
      expected_rsps.push_back(r);
   endfunction

   function automatic void predict_results(input req_type cmd);
      int n;
      int removed;
      int prev;
      logic [7:0] b;
      case (cmd.mode)
         MODE_PUT: begin
            if (ring_fill < DEPTH) begin
               ring_bytes[ring_wr] = cmd.put_byte;
               ring_wr = (ring_wr + 1 == DEPTH) ? 0 : ring_wr + 1;
               ring_fill++;
               push_result(8'h00, 1'b0, 1'b1, 1'b1, 0);
            end else begin
               push_result(8'h00, 1'b0, 1'b1, 1'b0, 0);
            end
         end
         MODE_GET: begin
            n = cmd.read_limit;
            if (n > MAX_RES) n = MAX_RES;
            if (n > ring_fill) n = ring_fill;
            if (n == 0) begin
               push_result(8'h00, 1'b0, 1'b1, 1'b0, 0);
            end
            for (int k = 0; k < n; k++) begin
               b = ring_bytes[ring_rd];
               ring_rd = (ring_rd + 1 == DEPTH) ? 0 : ring_rd + 1;
               ring_fill--;
               push_result(b, 1'b1, (b == cmd.stop_byte) || (k + 1 == n), 1'b0, 0);
               if (b == cmd.stop_byte) break;
            end
         end
         MODE_DROP: begin
            removed = 0;
            prev = (ring_wr == 0) ? DEPTH - 1 : ring_wr - 1;
            while (ring_fill != 0 && ring_bytes[prev] != cmd.stop_byte) begin
               ring_wr = prev;
               ring_fill--;
               removed++;
               prev = (ring_wr == 0) ? DEPTH - 1 : ring_wr - 1;
            end
            push_result(8'h00, 1'b0, 1'b1, 1'b0, removed);
         end
         default: begin
            push_result(8'h00, 1'b0, 1'b1, 1'b0, 0);
         end
      endcase
   endfunction

   function automatic void compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_results(cmd_on_bus);
            cmds_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               cmd_on_bus = pending_cmds.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {1'b0, cmd_on_bus.stop_byte, cmd_on_bus.read_limit,
                              cmd_on_bus.put_byte};
               req_tuser  <= cmd_on_bus.mode;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsps_seen++;
            if (expected_rsps.size() == 0) begin
               $error("result transaction with no pending expectation: tdata %h", rsp_tdata);
               error_count++;
            end else begin
               want = expected_rsps.pop_front();
               compare_field("data_byte", want.data_byte, rsp_tdata[7:0]);
               compare_field("byte_valid", want.byte_valid, rsp_tuser);
               compare_field("last", want.last, rsp_tlast);
               compare_field("accepted", want.accepted, rsp_tdata[8]);
               compare_field("dropped_count", want.dropped_count, rsp_tdata[19:9]);
               compare_field("occupancy", want.occupancy, rsp_tdata[30:20]);
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Watchdog expired after %0d cycles without a transaction.", idle_cycles);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   task automatic queue_cmd(input logic [MODE_W-1:0] mode, input logic [7:0] put_byte,
                            input logic [6:0] limit, input logic [7:0] stop);
      req_type r;
      r.mode       = mode;
      r.put_byte   = put_byte;
      r.read_limit = limit;
      r.stop_byte  = stop;
      pending_cmds.push_back(r);
      cmds_queued++;
   endtask

   function automatic logic [6:0] pick_limit();
      int p;
      p = $urandom_range(99);
      if (p < 5) return 7'd0;
      if (p < 12) return 7'($urandom_range(127, 65));
      return 7'($urandom_range(64, 1));
   endfunction

   task automatic queue_random_burst();
      int p;
      int len;
      logic [7:0] delim;
      delim = 8'($urandom_range(255));
      p = $urandom_range(99);
      if (p < 45) begin
         len = $urandom_range(12, 1);
         for (int k = 0; k < len; k++) begin
            queue_cmd(MODE_PUT, (k == len - 1) ? delim : 8'($urandom), 7'($urandom),
                      8'($urandom));
         end
         if ($urandom_range(3) != 0) queue_cmd(MODE_GET, 8'($urandom), pick_limit(), delim);
      end else if (p < 60) begin
         len = $urandom_range(6, 1);
         queue_cmd(MODE_PUT, delim, 7'($urandom), 8'($urandom));
         for (int k = 0; k < len; k++) begin
            queue_cmd(MODE_PUT, 8'($urandom), 7'($urandom), 8'($urandom));
         end
         queue_cmd(MODE_DROP, 8'($urandom), 7'($urandom), delim);
      end else if (p < 75) begin
         queue_cmd(MODE_GET, 8'($urandom), pick_limit(), 8'h00);
      end else if (p < 85) begin
         queue_cmd(MODE_GET, 8'($urandom), pick_limit(), delim);
      end else if (p < 92) begin
         queue_cmd(MODE_DROP, 8'($urandom), 7'($urandom), delim);
      end else if (p < 95) begin
         queue_cmd(MODE_UNUSED, 8'($urandom), 7'($urandom), 8'($urandom));
      end else begin
         queue_cmd(MODE_PUT, 8'($urandom), 7'($urandom), 8'($urandom));
      end
   endtask

   task automatic wait_drained();
      while (pending_cmds.size() != 0 || req_tvalid || expected_rsps.size() != 0) begin
         @(negedge clock);
      end
   endtask

   initial begin
      int phase_target;
      int top_up;
      ring_rd     = 0;
      ring_wr     = 0;
      ring_fill   = 0;
      error_count = 0;
      cmds_queued = 0;
      cmds_taken  = 0;
      rsps_seen   = 0;
      idle_cycles = 0;
      send_idle_pct = 11;
      recv_idle_pct = 78;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Empty-FIFO get and drop, the unused mode, zero and saturating limits,
      // stop on a popped zero, drops that remove nothing, part and all.
      queue_cmd(MODE_GET, 8'h00, 7'd5, 8'h00);
      queue_cmd(MODE_DROP, 8'h00, 7'd0, 8'h33);
      queue_cmd(MODE_UNUSED, 8'h00, 7'd0, 8'h00);
      queue_cmd(MODE_PUT, 8'h00, 7'd0, 8'h00);
      queue_cmd(MODE_PUT, 8'hFF, 7'h7F, 8'hFF);
      queue_cmd(MODE_PUT, 8'h5A, 7'd3, 8'h10);
      queue_cmd(MODE_PUT, 8'h81, 7'd9, 8'h02);
      queue_cmd(MODE_GET, 8'hFF, 7'd0, 8'h00);
      queue_cmd(MODE_GET, 8'h00, 7'd127, 8'h00);
      queue_cmd(MODE_GET, 8'h00, 7'd1, 8'h12);
      queue_cmd(MODE_PUT, 8'h33, 7'd0, 8'h00);
      queue_cmd(MODE_PUT, 8'h7E, 7'd0, 8'h00);
      queue_cmd(MODE_DROP, 8'h00, 7'd0, 8'h7E);
      queue_cmd(MODE_DROP, 8'hFF, 7'h7F, 8'h81);
      queue_cmd(MODE_PUT, 8'hC3, 7'd0, 8'h00);
      queue_cmd(MODE_PUT, 8'h24, 7'd0, 8'h00);
      queue_cmd(MODE_GET, 8'h00, 7'd64, 8'h81);
      queue_cmd(MODE_GET, 8'h00, 7'd3, 8'hAA);
      queue_cmd(MODE_PUT, 8'h11, 7'd0, 8'h00);
      queue_cmd(MODE_DROP, 8'h00, 7'd0, 8'h99);
      queue_cmd(MODE_UNUSED, 8'hFF, 7'h7F, 8'hFF);

      for (int phase = 0; phase < 3; phase++) begin
         phase_target = cmds_queued + ITEMS_PER_PHASE;
         while (cmds_queued < phase_target) queue_random_burst();
         if (phase == 2) begin
            // Fill to the brim, push past full, wrap the pointers, then drop with a stop byte no new byte carries.
            wait_drained();
            top_up = DEPTH - ring_fill + 3;
            for (int k = 0; k < top_up; k++) begin
               queue_cmd(MODE_PUT, 8'($urandom_range(254, 1)), 7'($urandom), 8'($urandom));
            end
            queue_cmd(MODE_GET, 8'($urandom), 7'd100, 8'h00);
            for (int k = 0; k < MAX_RES + 1; k++) begin
               queue_cmd(MODE_PUT, 8'($urandom_range(254, 1)), 7'($urandom), 8'($urandom));
            end
            queue_cmd(MODE_DROP, 8'($urandom), 7'($urandom), 8'hFF);
            for (int k = 0; k < 40; k++) queue_random_burst();
         end
         wait_drained();
         if (phase == 0) begin
            send_idle_pct = 78;
            recv_idle_pct = 11;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
      end

      repeat (40) @(posedge clock);
      $display("Run covered %0d commands and %0d results over three flow-control phases,",
               cmds_taken, rsps_seen);
      $display("including put to a full FIFO, pointer wrap and a drop of the whole FIFO.");
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+design
design/dbrf_pkg.sv
design/dbrf_mem.sv
design/dbrf_ctrl.sv
design/delimited_byte_ring_fifo.sv
tb/delimited_byte_ring_fifo_tb.sv
